// ===== hdl/gtr_pkg.sv =====
`timescale 1ns / 1ps

package gtr_pkg;

  // Depth of the brace and bracket group stack.
  localparam int GROUP_DEPTH = 16;
  localparam int GROUP_IDX_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int GROUP_CNT_W = $clog2(GROUP_DEPTH + 1);

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASH_SYNTAX    = 3'd0,
    CFG_CAPTURE_GROUPS = 3'd1,
    CFG_GLOBSTAR_MODE  = 3'd2,
    CFG_ANCHOR_FULL    = 3'd3,
    CFG_PATH_MODE      = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TRAILING_ESC   = 3'd1,
    ST_OPEN_BRACKET   = 3'd2,
    ST_OPEN_BRACE     = 3'd3,
    ST_NESTED_BRACKET = 3'd4,
    ST_TOO_DEEP       = 3'd5
  } status_t;

  // Which wildcard text a resolved star run expands to.
  typedef enum logic [2:0] {
    STAR_NONE     = 3'd0,
    STAR_DOT      = 3'd1,
    STAR_DOT_CAP  = 3'd2,
    STAR_SEG      = 3'd3,
    STAR_SEG_CAP  = 3'd4,
    STAR_GLOB     = 3'd5,
    STAR_GLOB_CAP = 3'd6
  } star_sel_t;

  // One queued command: the results caused by one accepted item, in order
  // caret, star text, character bytes, dollar, status item.
  typedef struct packed {
    logic            done;
    logic            caret;
    star_sel_t       star;
    logic [1:0]      chr_n;
    logic [2:0][7:0] chr;
    logic            dollar;
    logic            status_item;
    status_t         status;
  } cmd_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRK   = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRK   = 8'h5D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

// ===== hdl/glob_to_regex_transducer.sv =====
`timescale 1ns / 1ps

// Glob to regular-expression transducer.
// Input channel (in_*): one item per glob character, tuser = 0 and the byte in
// tdata, or an end-of-pattern item with tuser = 1. Output channel (out_*): the
// regex text, one byte per item, tlast on the last result of each input item.
// The end-of-pattern item always closes with a status item (has_byte = 0) that
// carries the error code, zero when the pattern was well formed.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must do
// so only while idle, as the block itself does not enforce it. The front stage
// decodes an accepted item in its cycle into a command, which a four-entry command
// queue hands to the back stage; the back stage walks the command and registers
// one result byte per cycle while out_tready allows. A command passes through the
// queue and the back stage's output register before its first result is offered.
// Input items are taken one per cycle while the queue has room, and an item
// causes up to twenty-one results, or none.
// Reset (synchronous, rst_n low) clears the pattern state and the queue and
// returns the registers to their defaults. When the receiver holds out_tready
// low the output item holds, the queue fills and in_tready then drops.
module glob_to_regex_transducer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gtr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] pattern_char
  input  logic [0:0]                      in_tuser,   // [0] kind
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] out_byte, [10:8] status
  output logic [1:0]                      out_tuser,  // [0] has_byte, [1] pattern_done
  output logic                            out_tlast   // last_of_run
);
  import gtr_pkg::*;

  cmd_t       push_cmd, head;
  logic       q_push, q_full, q_pop, q_empty;
  logic [7:0] out_byte;
  logic       out_has_byte, out_done;
  logic [2:0] out_status;

  gtr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser[0]),
    .in_char   (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  gtr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  gtr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_tlast),
    .out_done     (out_done),
    .out_status   (out_status)
  );

  assign out_tdata = {5'b00000, out_status, out_byte};
  assign out_tuser = {out_done, out_has_byte};

endmodule

// ===== hdl/gtr_front.sv =====
`timescale 1ns / 1ps

module gtr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [gtr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                         cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic                         in_kind,
  input  logic [7:0]                   in_char,
  input  logic                         q_full,
  output logic                         q_push,
  output gtr_pkg::cmd_t                q_cmd
);
  import gtr_pkg::*;

  logic bash_r, capture_r, globstar_r, anchor_r, path_r;

  logic                   escape_r, escape_nxt;
  logic [GROUP_DEPTH-1:0] stack_r, stack_nxt;
  logic [GROUP_CNT_W-1:0] depth_r, depth_nxt;
  logic                   bracket_r, bracket_nxt;
  logic [7:0]             prev_r, prev_nxt;
  logic [7:0]             prev2_r, prev2_nxt;
  logic                   star_r, star_nxt;
  logic                   multi_r, multi_nxt;
  logic                   sesc_r, sesc_nxt;
  logic [7:0]             before_r, before_nxt;
  logic                   started_r, started_nxt;
  status_t                err_r, err_nxt;

  logic                   accept;
  logic [7:0]             next_c;
  logic                   star_cap;
  logic                   globstar_hit;
  star_sel_t              star_sel;
  logic [GROUP_CNT_W-1:0] depth_m1;
  logic [GROUP_IDX_W-1:0] top_idx;
  logic                   top_none, top_bracket, top_brace;
  logic                   stack_full;
  logic                   esc;
  status_t                end_status;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bash_r     <= 1'b1;
      capture_r  <= 1'b0;
      globstar_r <= 1'b0;
      anchor_r   <= 1'b1;
      path_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASH_SYNTAX:    bash_r     <= cfg_wdata;
        CFG_CAPTURE_GROUPS: capture_r  <= cfg_wdata;
        CFG_GLOBSTAR_MODE:  globstar_r <= cfg_wdata;
        CFG_ANCHOR_FULL:    anchor_r   <= cfg_wdata;
        CFG_PATH_MODE:      path_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Top of the group stack; only entries below the depth are ever read.
  assign depth_m1    = depth_r - 1'b1;
  assign top_idx     = depth_m1[GROUP_IDX_W-1:0];
  assign top_none    = (depth_r == '0);
  assign top_bracket = !top_none && stack_r[top_idx];
  assign top_brace   = !top_none && !stack_r[top_idx];
  assign stack_full  = (depth_r >= GROUP_CNT_W'(GROUP_DEPTH));
  assign esc         = escape_r;

  // The end marker resolves a held star run as if a zero byte followed.
  assign next_c       = in_kind ? CH_NUL : in_char;
  assign star_cap     = capture_r && !sesc_r;
  assign globstar_hit = globstar_r && multi_r &&
                        (before_r == CH_SLASH || before_r == CH_NUL) &&
                        (next_c == CH_SLASH || next_c == CH_NUL);

  always_comb begin
    if (!globstar_r) begin
      star_sel = star_cap ? STAR_DOT_CAP : STAR_DOT;
    end else if (globstar_hit) begin
      star_sel = star_cap ? STAR_GLOB_CAP : STAR_GLOB;
    end else begin
      star_sel = star_cap ? STAR_SEG_CAP : STAR_SEG;
    end
  end

  always_comb begin
    if (err_r != ST_OK) begin
      end_status = err_r;
    end else if (escape_r) begin
      end_status = ST_TRAILING_ESC;
    end else if (!top_none) begin
      end_status = top_bracket ? ST_OPEN_BRACKET : ST_OPEN_BRACE;
    end else begin
      end_status = ST_OK;
    end
  end

  always_comb begin
    escape_nxt  = escape_r;
    stack_nxt   = stack_r;
    depth_nxt   = depth_r;
    bracket_nxt = bracket_r;
    prev_nxt    = prev_r;
    prev2_nxt   = prev2_r;
    star_nxt    = star_r;
    multi_nxt   = multi_r;
    sesc_nxt    = sesc_r;
    before_nxt  = before_r;
    started_nxt = started_r;
    err_nxt     = err_r;
    q_cmd       = '0;
    q_push      = 1'b0;

    if (accept && !in_kind) begin
      if (err_r == ST_OK) begin
        started_nxt = 1'b1;
        q_cmd.caret = !started_r && anchor_r;
        if (star_r && in_char == CH_STAR) begin
          multi_nxt = 1'b1;
        end else begin
          if (star_r) begin
            q_cmd.star = star_sel;
            star_nxt   = 1'b0;
            multi_nxt  = 1'b0;
            sesc_nxt   = 1'b0;
          end
          // A globstar swallows the slash or zero byte that follows it.
          if (!(star_r && globstar_hit)) begin
            escape_nxt = 1'b0;
            case (in_char)
              CH_BSLASH: begin
                if (esc) begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_BSLASH;
                end else begin
                  escape_nxt = 1'b1;
                end
              end
              CH_DOLLAR, CH_CARET, CH_PLUS, CH_DOT, CH_LPAR, CH_RPAR,
              CH_EQUAL, CH_BANG, CH_BAR: begin
                if (esc) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = in_char;
                end else begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = in_char;
                end
              end
              CH_QUEST: begin
                if (esc) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_QUEST;
                end else if (bash_r && capture_r) begin
                  q_cmd.chr_n  = 2'd3;
                  q_cmd.chr[0] = CH_LPAR;
                  q_cmd.chr[1] = CH_DOT;
                  q_cmd.chr[2] = CH_RPAR;
                end else if (bash_r) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_DOT;
                end else begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_QUEST;
                end
              end
              CH_LBRK: begin
                if (esc || (bash_r && !capture_r)) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_LBRK;
                end else if (!bash_r) begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_LBRK;
                end else if (bracket_r) begin
                  err_nxt = ST_NESTED_BRACKET;
                end else if (stack_full) begin
                  err_nxt = ST_TOO_DEEP;
                end else begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_LPAR;
                  q_cmd.chr[1] = CH_LBRK;
                  stack_nxt[depth_r[GROUP_IDX_W-1:0]] = 1'b1;
                  depth_nxt    = depth_r + 1'b1;
                  bracket_nxt  = 1'b1;
                end
              end
              CH_RBRK: begin
                if (esc || (bash_r && !capture_r)) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_RBRK;
                end else if (bash_r && top_bracket) begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_RBRK;
                  q_cmd.chr[1] = CH_RPAR;
                  depth_nxt    = depth_m1;
                  bracket_nxt  = 1'b0;
                end else begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_RBRK;
                end
              end
              CH_LBRACE: begin
                if (esc) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_LBRACE;
                end else if (!bash_r) begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_LBRACE;
                end else if (stack_full) begin
                  err_nxt = ST_TOO_DEEP;
                end else begin
                  stack_nxt[depth_r[GROUP_IDX_W-1:0]] = 1'b0;
                  depth_nxt    = depth_r + 1'b1;
                  q_cmd.chr[0] = CH_LPAR;
                  q_cmd.chr[1] = CH_QUEST;
                  q_cmd.chr[2] = CH_COLON;
                  q_cmd.chr_n  = capture_r ? 2'd1 : 2'd3;
                end
              end
              CH_RBRACE: begin
                if (esc) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_RBRACE;
                end else if (bash_r && top_brace) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_RPAR;
                  depth_nxt    = depth_m1;
                end else begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_RBRACE;
                end
              end
              CH_COMMA: begin
                if (!esc && !top_none) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = top_brace ? CH_BAR : CH_COMMA;
                end else begin
                  q_cmd.chr_n  = 2'd2;
                  q_cmd.chr[0] = CH_BSLASH;
                  q_cmd.chr[1] = CH_COMMA;
                end
              end
              CH_STAR: begin
                if (esc && !path_r) begin
                  q_cmd.chr_n  = 2'd1;
                  q_cmd.chr[0] = CH_STAR;
                end else begin
                  star_nxt   = 1'b1;
                  multi_nxt  = 1'b0;
                  sesc_nxt   = esc;
                  before_nxt = esc ? prev2_r : prev_r;
                end
              end
              default: begin
                q_cmd.chr_n  = 2'd1;
                q_cmd.chr[0] = in_char;
              end
            endcase
          end
        end
        prev2_nxt = prev_r;
        prev_nxt  = in_char;
        q_push    = q_cmd.caret || (q_cmd.star != STAR_NONE) || (q_cmd.chr_n != 2'd0);
      end
    end else if (accept) begin
      if (end_status == ST_OK) begin
        q_cmd.caret  = !started_r && anchor_r;
        q_cmd.star   = star_r ? star_sel : STAR_NONE;
        q_cmd.dollar = anchor_r;
      end
      q_cmd.status_item = 1'b1;
      q_cmd.status      = end_status;
      q_cmd.done        = 1'b1;
      q_push            = 1'b1;
      escape_nxt  = 1'b0;
      depth_nxt   = '0;
      bracket_nxt = 1'b0;
      prev_nxt    = CH_NUL;
      prev2_nxt   = CH_NUL;
      star_nxt    = 1'b0;
      multi_nxt   = 1'b0;
      sesc_nxt    = 1'b0;
      before_nxt  = CH_NUL;
      started_nxt = 1'b0;
      err_nxt     = ST_OK;
    end
  end

  // The stack holds no reset: entries are written before they are read.
  always_ff @(posedge clk) begin
    stack_r <= stack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r  <= 1'b0;
      depth_r   <= '0;
      bracket_r <= 1'b0;
      prev_r    <= CH_NUL;
      prev2_r   <= CH_NUL;
      star_r    <= 1'b0;
      multi_r   <= 1'b0;
      sesc_r    <= 1'b0;
      before_r  <= CH_NUL;
      started_r <= 1'b0;
      err_r     <= ST_OK;
    end else begin
      escape_r  <= escape_nxt;
      depth_r   <= depth_nxt;
      bracket_r <= bracket_nxt;
      prev_r    <= prev_nxt;
      prev2_r   <= prev2_nxt;
      star_r    <= star_nxt;
      multi_r   <= multi_nxt;
      sesc_r    <= sesc_nxt;
      before_r  <= before_nxt;
      started_r <= started_nxt;
      err_r     <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= GROUP_CNT_W'(GROUP_DEPTH))
    else $error("group depth beyond stack size");

  a_bracket_on_stack: assert property (@(posedge clk) disable iff (!rst_n)
    bracket_r |-> (depth_r != '0))
    else $error("open bracket with empty group stack");

  a_end_always_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind) |-> (q_push && q_cmd.status_item))
    else $error("end of pattern gave no status command");
`endif

endmodule

// ===== hdl/gtr_queue.sv =====
`timescale 1ns / 1ps

module gtr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gtr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output gtr_pkg::cmd_t head,
  output logic          empty
);
  import gtr_pkg::*;

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  cmd_t             mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command queue underflow");
`endif

endmodule

// ===== hdl/gtr_back.sv =====
`timescale 1ns / 1ps

module gtr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  gtr_pkg::cmd_t head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_byte,
  output logic          out_has_byte,
  output logic          out_last,
  output logic          out_done,
  output logic [2:0]    out_status
);
  import gtr_pkg::*;

  typedef enum logic [4:0] {
    SEG_CARET  = 5'b00001,
    SEG_STAR   = 5'b00010,
    SEG_CHR    = 5'b00100,
    SEG_DOLLAR = 5'b01000,
    SEG_STATUS = 5'b10000
  } seg_t;

  localparam int STR_MAX = 19;

  function automatic logic [4:0] star_len(star_sel_t sel);
    logic [4:0] len;
    case (sel)
      STAR_DOT:      len = 5'd2;
      STAR_DOT_CAP:  len = 5'd4;
      STAR_SEG:      len = 5'd5;
      STAR_SEG_CAP:  len = 5'd7;
      STAR_GLOB:     len = 5'd17;
      STAR_GLOB_CAP: len = 5'd19;
      default:       len = 5'd1;
    endcase
    return len;
  endfunction

  // Strings are right-aligned, so character i sits len-1-i bytes from the bottom.
  function automatic logic [7:0] star_byte(star_sel_t sel, logic [4:0] idx);
    logic [8*STR_MAX-1:0] s;
    logic [4:0]           pos;
    case (sel)
      STAR_DOT:      s = ".*";
      STAR_DOT_CAP:  s = "(.*)";
      STAR_SEG:      s = "[^/]*";
      STAR_SEG_CAP:  s = "([^/]*)";
      STAR_GLOB:     s = "(?:[^/]*(?:/|$))*";
      STAR_GLOB_CAP: s = "((?:[^/]*(?:/|$))*)";
      default:       s = '0;
    endcase
    pos = star_len(sel) - 5'd1 - idx;
    return s[{pos, 3'b000} +: 8];
  endfunction

  logic       start_r;
  seg_t       seg_r;
  logic [4:0] idx_r;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       has_r, last_r, done_r;
  logic [2:0] status_r;

  logic [4:0] pres, first_v, seg_v, above, nxt_v;
  seg_t       eff_seg;
  logic [4:0] eff_idx;
  logic [4:0] seg_len;
  logic       seg_end, cmd_last;
  logic       advance;
  logic [7:0] cur_byte;

  assign pres    = {head.status_item, head.dollar, head.chr_n != 2'd0,
                    head.star != STAR_NONE, head.caret};
  assign first_v = pres & (~pres + 5'd1);
  assign eff_seg = start_r ? seg_t'(first_v) : seg_r;
  assign eff_idx = start_r ? 5'd0 : idx_r;
  assign seg_v   = eff_seg;
  assign above   = pres & ~(seg_v | (seg_v - 5'd1));
  assign nxt_v   = above & (~above + 5'd1);

  always_comb begin
    case (eff_seg)
      SEG_CARET: begin
        seg_len  = 5'd1;
        cur_byte = CH_CARET;
      end
      SEG_STAR: begin
        seg_len  = star_len(head.star);
        cur_byte = star_byte(head.star, eff_idx);
      end
      SEG_CHR: begin
        seg_len  = {3'b000, head.chr_n};
        cur_byte = head.chr[eff_idx[1:0]];
      end
      SEG_DOLLAR: begin
        seg_len  = 5'd1;
        cur_byte = CH_DOLLAR;
      end
      default: begin
        seg_len  = 5'd1;
        cur_byte = CH_NUL;
      end
    endcase
  end

  assign seg_end  = (eff_idx == seg_len - 5'd1);
  assign cmd_last = seg_end && (above == 5'd0);
  assign advance  = !q_empty && (!valid_r || out_tready);
  assign q_pop    = advance && cmd_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      seg_r   <= SEG_CARET;
      idx_r   <= 5'd0;
      valid_r <= 1'b0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        if (cmd_last) begin
          start_r <= 1'b1;
        end else if (seg_end) begin
          start_r <= 1'b0;
          seg_r   <= seg_t'(nxt_v);
          idx_r   <= 5'd0;
        end else begin
          start_r <= 1'b0;
          seg_r   <= eff_seg;
          idx_r   <= eff_idx + 5'd1;
        end
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r   <= cur_byte;
      has_r    <= (eff_seg != SEG_STATUS);
      last_r   <= cmd_last;
      done_r   <= head.done;
      status_r <= (eff_seg == SEG_STATUS) ? head.status : ST_OK;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_byte     = byte_r;
  assign out_has_byte = has_r;
  assign out_last     = last_r;
  assign out_done     = done_r;
  assign out_status   = status_r;

`ifndef SYNTHESIS
  a_status_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !has_r) |-> (last_r && done_r && byte_r == CH_NUL))
    else $error("status item not the closing result of its pattern");
`endif

endmodule

// ===== tb/sv/glob_to_regex_transducer_tb.sv =====
`timescale 1ns / 1ps

module glob_to_regex_transducer_tb;
  import gtr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } glob_item_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       last_of_run;
    logic       pattern_done;
    status_t    status;
  } regex_result_t;

  typedef enum {GRP_NONE, GRP_BRACKET, GRP_BRACE} grp_top_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_wdata = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [15:0]            out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  glob_to_regex_transducer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  glob_item_t    pending_glob[$];
  regex_result_t regex_expect[$];
  logic [7:0]    regex_text[$];

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fail_cnt = 0;
  int          queued_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;

  // Translator state and register copies.
  bit         r_bash = 1'b1;
  bit         r_cap = 1'b0;
  bit         r_glob = 1'b0;
  bit         r_anchor = 1'b1;
  bit         r_path = 1'b0;
  bit         esc_pend;
  bit         grp_stack [GROUP_DEPTH];
  int         grp_depth;
  bit         brk_open;
  logic [7:0] prev1_ch;
  logic [7:0] prev2_ch;
  bit         star_pend;
  bit         star_multi;
  bit         star_esc;
  logic [7:0] star_before;
  bit         started;
  status_t    latched_err;

  task automatic clear_pattern();
    esc_pend = 1'b0;
    grp_depth = 0;
    brk_open = 1'b0;
    prev1_ch = CH_NUL;
    prev2_ch = CH_NUL;
    star_pend = 1'b0;
    star_multi = 1'b0;
    star_esc = 1'b0;
    star_before = CH_NUL;
    started = 1'b0;
    latched_err = ST_OK;
  endtask

  initial clear_pattern();

  function automatic void emit_byte(input logic [7:0] b);
    regex_text = {regex_text, b};
  endfunction

  function automatic void emit_str(input string s);
    for (int i = 0; i < s.len(); i++) emit_byte(s[i]);
  endfunction

  function automatic grp_top_t group_top();
    if (grp_depth == 0) return GRP_NONE;
    return grp_stack[grp_depth-1] ? GRP_BRACKET : GRP_BRACE;
  endfunction

  // Writes out the held run of stars; returns 1 when it swallows the next byte.
  function automatic bit flush_star_run(input logic [7:0] next_ch);
    bit cap;
    bit swallowed;
    cap = r_cap && !star_esc;
    swallowed = 1'b0;
    if (!r_glob) begin
      emit_str(cap ? "(.*)" : ".*");
    end else if (star_multi && (star_before == CH_SLASH || star_before == CH_NUL) &&
                 (next_ch == CH_SLASH || next_ch == CH_NUL)) begin
      emit_str(cap ? "((?:[^/]*(?:/|$))*)" : "(?:[^/]*(?:/|$))*");
      swallowed = 1'b1;
    end else begin
      emit_str(cap ? "([^/]*)" : "[^/]*");
    end
    star_pend = 1'b0;
    star_multi = 1'b0;
    star_esc = 1'b0;
    return swallowed;
  endfunction

  task automatic translate_char(input logic [7:0] c);
    bit esc;
    esc = esc_pend;
    case (c)
      CH_BSLASH: begin
        if (esc) begin
          emit_str("\\\\");
          esc_pend = 1'b0;
        end else begin
          esc_pend = 1'b1;
        end
        return;
      end
      CH_DOLLAR, CH_CARET, CH_PLUS, CH_DOT, CH_LPAR, CH_RPAR, CH_EQUAL, CH_BANG,
      CH_BAR: begin
        if (!esc) emit_byte(CH_BSLASH);
        emit_byte(c);
      end
      CH_QUEST: begin
        if (esc) emit_byte(c);
        else if (r_bash) emit_str(r_cap ? "(.)" : ".");
        else emit_str("\\?");
      end
      CH_LBRK: begin
        if (!esc) begin
          if (r_bash) begin
            if (r_cap) begin
              if (brk_open) begin
                latched_err = ST_NESTED_BRACKET;
                return;
              end
              if (grp_depth >= GROUP_DEPTH) begin
                latched_err = ST_TOO_DEEP;
                return;
              end
              emit_byte(CH_LPAR);
              grp_stack[grp_depth] = 1'b1;
              grp_depth++;
              brk_open = 1'b1;
            end
          end else begin
            emit_byte(CH_BSLASH);
          end
        end
        emit_byte(c);
      end
      CH_RBRK: begin
        if (esc) begin
          emit_byte(c);
        end else if (r_bash) begin
          if (r_cap) begin
            if (group_top() == GRP_BRACKET) begin
              emit_str("])");
              grp_depth--;
              brk_open = 1'b0;
            end else begin
              emit_str("\\]");
            end
          end else begin
            emit_byte(c);
          end
        end else begin
          emit_str("\\]");
        end
      end
      CH_LBRACE: begin
        if (!esc) begin
          if (r_bash) begin
            if (grp_depth >= GROUP_DEPTH) begin
              latched_err = ST_TOO_DEEP;
              return;
            end
            grp_stack[grp_depth] = 1'b0;
            grp_depth++;
            emit_byte(CH_LPAR);
            if (!r_cap) emit_str("?:");
            return;
          end
          emit_byte(CH_BSLASH);
        end
        emit_byte(c);
      end
      CH_RBRACE: begin
        if (!esc) begin
          if (group_top() == GRP_BRACE && r_bash) begin
            grp_depth--;
            emit_byte(CH_RPAR);
            return;
          end
          emit_byte(CH_BSLASH);
        end
        emit_byte(c);
      end
      CH_COMMA: begin
        if (!esc && group_top() != GRP_NONE) begin
          emit_byte(group_top() == GRP_BRACE ? CH_BAR : CH_COMMA);
        end else begin
          emit_str("\\,");
        end
      end
      CH_STAR: begin
        if (esc && !r_path) begin
          emit_byte(c);
        end else begin
          star_pend = 1'b1;
          star_multi = 1'b0;
          star_esc = esc;
          star_before = esc ? prev2_ch : prev1_ch;
        end
      end
      default: emit_byte(c);
    endcase
    esc_pend = 1'b0;
  endtask

  // Works out every result caused by one accepted item and queues them.
  task automatic translate_item(input logic kind, input logic [7:0] c);
    regex_result_t r;
    status_t       st;
    bit            swallowed;
    regex_text.delete();
    if (kind == 1'b0) begin
      if (latched_err != ST_OK) return;
      if (!started) begin
        started = 1'b1;
        if (r_anchor) emit_byte(CH_CARET);
      end
      if (star_pend && c == CH_STAR) begin
        star_multi = 1'b1;
      end else begin
        swallowed = 1'b0;
        if (star_pend) swallowed = flush_star_run(c);
        if (!swallowed) translate_char(c);
      end
      prev2_ch = prev1_ch;
      prev1_ch = c;
      for (int i = 0; i < regex_text.size(); i++) begin
        r.text_byte = regex_text[i];
        r.has_byte = 1'b1;
        r.last_of_run = (i == regex_text.size() - 1);
        r.pattern_done = 1'b0;
        r.status = ST_OK;
        regex_expect = {regex_expect, r};
      end
    end else begin
      st = latched_err;
      if (st == ST_OK) begin
        if (esc_pend) st = ST_TRAILING_ESC;
        else if (grp_depth > 0)
          st = (group_top() == GRP_BRACKET) ? ST_OPEN_BRACKET : ST_OPEN_BRACE;
      end
      if (st == ST_OK) begin
        if (!started && r_anchor) emit_byte(CH_CARET);
        if (star_pend) void'(flush_star_run(CH_NUL));
        if (r_anchor) emit_byte(CH_DOLLAR);
      end
      foreach (regex_text[i]) begin
        r.text_byte = regex_text[i];
        r.has_byte = 1'b1;
        r.last_of_run = 1'b0;
        r.pattern_done = 1'b1;
        r.status = ST_OK;
        regex_expect = {regex_expect, r};
      end
      r.text_byte = CH_NUL;
      r.has_byte = 1'b0;
      r.last_of_run = 1'b1;
      r.pattern_done = 1'b1;
      r.status = st;
      regex_expect = {regex_expect, r};
      clear_pattern();
    end
  endtask

  always @(posedge clk) begin : drive_proc
    glob_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) translate_item(in_tuser[0], in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_glob.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_glob.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.kind;
          in_tdata <= nxt.ch;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_failure(input string what, input regex_result_t got,
                                input regex_result_t want);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%s (byte has last done status): got %h %b %b %b %0d, expected %h %b %b %b %0d",
               what, got.text_byte, got.has_byte, got.last_of_run, got.pattern_done,
               got.status, want.text_byte, want.has_byte, want.last_of_run,
               want.pattern_done, want.status);
  endtask

  always @(posedge clk) begin : check_proc
    regex_result_t got;
    regex_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.text_byte = out_tdata[7:0];
        got.has_byte = out_tuser[0];
        got.last_of_run = out_tlast;
        got.pattern_done = out_tuser[1];
        got.status = status_t'(out_tdata[10:8]);
        if (regex_expect.size() == 0) begin
          want = '0;
          report_failure("unexpected item", got, want);
        end else begin
          want = regex_expect.pop_front();
          if (got.text_byte !== want.text_byte || got.has_byte !== want.has_byte ||
              got.last_of_run !== want.last_of_run ||
              got.pattern_done !== want.pattern_done || got.status !== want.status)
            report_failure("mismatch", got, want);
        end
      end
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off, started by toggling hold_req.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] c);
    glob_item_t it;
    it.kind = 1'b0;
    it.ch = c;
    pending_glob = {pending_glob, it};
    queued_cnt++;
  endtask

  task automatic push_end();
    glob_item_t it;
    it.kind = 1'b1;
    it.ch = 8'($urandom_range(0, 255));
    pending_glob = {pending_glob, it};
    queued_cnt++;
  endtask

  function automatic logic [7:0] pick_lit();
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 18))
      0:  return CH_STAR;
      1:  return CH_QUEST;
      2:  return CH_LBRK;
      3:  return CH_RBRK;
      4:  return CH_LBRACE;
      5:  return CH_RBRACE;
      6:  return CH_COMMA;
      7:  return CH_BSLASH;
      8:  return CH_SLASH;
      9:  return CH_DOLLAR;
      10: return CH_CARET;
      11: return CH_PLUS;
      12: return CH_DOT;
      13: return CH_LPAR;
      14: return CH_RPAR;
      15: return CH_EQUAL;
      16: return CH_BANG;
      17: return CH_NUL;
      default: return CH_BAR;
    endcase
  endfunction

  // A glob with random content, closed by the end marker.
  task automatic queue_pattern();
    int n_tok;
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1: push_char(pick_lit());
        2: begin
          if ($urandom_range(0, 1)) push_char(CH_SLASH);
          repeat ($urandom_range(1, 3)) push_char(CH_STAR);
          if ($urandom_range(0, 1)) push_char(CH_SLASH);
        end
        3: push_char(CH_QUEST);
        4: begin
          push_char(CH_LBRK);
          repeat ($urandom_range(1, 3)) push_char(pick_lit());
          push_char(CH_RBRK);
        end
        5: begin
          push_char(CH_LBRACE);
          push_char(pick_lit());
          push_char(CH_COMMA);
          push_char($urandom_range(0, 1) ? CH_STAR : pick_lit());
          push_char(CH_RBRACE);
        end
        6: begin
          push_char(CH_BSLASH);
          push_char(pick_op());
        end
        7: push_char(CH_SLASH);
        8: push_char(pick_op());
        default: push_char(CH_NUL);
      endcase
    end
    push_end();
  endtask

  // Opens enough groups to run past the stack depth now and then.
  task automatic queue_deep();
    int n;
    n = $urandom_range(14, 19);
    repeat (n) push_char($urandom_range(0, 7) == 0 ? CH_LBRK : CH_LBRACE);
    repeat ($urandom_range(0, n)) push_char($urandom_range(0, 1) ? CH_RBRACE : CH_RBRK);
    push_end();
  endtask

  task automatic run_phase(input int quota);
    int start_cnt;
    int pick;
    start_cnt = queued_cnt;
    while (queued_cnt - start_cnt < quota) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        queue_deep();
      end else if (pick <= 2) begin
        repeat ($urandom_range(1, 8)) push_char($urandom_range(0, 1) ? pick_op() :
                                                 8'($urandom_range(1, 255)));
        push_end();
      end else begin
        queue_pattern();
      end
    end
  endtask

  // Waits until every item is accepted and every result has come, then lets
  // items that cause no result leave the pipeline. The checks are made at the
  // falling edge, when the driver's updates have settled.
  task automatic drain();
    @(negedge clk);
    while (pending_glob.size() != 0 || in_tvalid || regex_expect.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input bit v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_BASH_SYNTAX:    r_bash = v;
      CFG_CAPTURE_GROUPS: r_cap = v;
      CFG_GLOBSTAR_MODE:  r_glob = v;
      CFG_ANCHOR_FULL:    r_anchor = v;
      CFG_PATH_MODE:      r_path = v;
      default: ;
    endcase
  endtask

  task automatic set_config(input bit bash, input bit cap, input bit glob,
                            input bit anchor, input bit path);
    drain();
    write_reg(CFG_BASH_SYNTAX, bash);
    write_reg(CFG_CAPTURE_GROUPS, cap);
    write_reg(CFG_GLOBSTAR_MODE, glob);
    write_reg(CFG_ANCHOR_FULL, anchor);
    write_reg(CFG_PATH_MODE, path);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    push_char(8'h01);
    push_char(CH_BSLASH);
    push_char(CH_STAR);
    push_char(CH_STAR);
    push_char(CH_STAR);
    push_char(CH_SLASH);
    push_char(CH_QUEST);
    push_char(CH_LBRK);
    push_char(8'hFF);
    push_char(CH_RBRK);
    push_char(CH_LBRACE);
    push_char(CH_NUL);
    push_char(CH_COMMA);
    push_char(CH_DOLLAR);
    push_char(CH_RBRACE);
    push_char(CH_BSLASH);
    push_char(CH_BSLASH);
    push_end();
    push_char(CH_BSLASH);
    push_end();
    push_end();
    // Leave a star run pending across a register change.
    push_char(CH_LOWER_A);
    push_char(CH_STAR);

    set_config(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    set_idle(64, 0);
    run_phase(18);

    set_config(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    set_idle(0, 64);
    run_phase(18);

    set_config(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    set_idle(11, 11);
    run_phase(18);

    set_config(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
    set_idle(0, 0);
    run_phase(18);

    set_config(1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    set_idle(64, 64);
    run_phase(18);

    // The receiver holds off while the sender keeps offering items, so the
    // command queue fills and the input stalls.
    set_config(1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    set_idle(0, 0);
    hold_req = ~hold_req;
    run_phase(18);
    drain();
    set_idle(11, 11);
    run_phase(8);

    drain();
    if (regex_expect.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
